// ----- sv/bitmap_frame_allocator_macros.svh -----
// assertion helpers for the frame allocator
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/bfa_pkg.sv -----
`default_nettype none
package bfa_pkg;

    // field and counter widths
    localparam int CNT_W       = 9;
    localparam int IDX_W       = 8;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int WORD_W      = 8;
    localparam int WORD_SH     = $clog2(WORD_W);
    localparam int WCNT_W      = CNT_W + 1 - WORD_SH;
    localparam int FRAME_LIMIT = 1 << (CNT_W - 1);

    localparam int MAX_FRAMES_DEF = 256;

    // register reset values
    localparam logic [CNT_W-1:0] FRAME_COUNT_RST     = CNT_W'(256);
    localparam logic [CNT_W-1:0] RESERVED_FRAMES_RST = CNT_W'(1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_FRAMES = 1'b1;

    // request actions
    localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FORMAT = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_RUN      = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_LEN    = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNFORMATTED = 2'd3;

    // run scanner control and result
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] start;
    } scan_res_t;

endpackage
`default_nettype wire

// ----- sv/bfa_ram.sv -----
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              clk,
    input  wire              we,
    input  wire [ADDR_W-1:0] waddr,
    input  wire [WIDTH-1:0]  wdata,
    input  wire              re,
    input  wire [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/bfa_scan.sv -----
`default_nettype none
module bfa_scan (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire bfa_pkg::scan_ctrl_t ctrl,
    input  wire [bfa_pkg::WORD_W-1:0] word,
    input  wire [bfa_pkg::CNT_W-1:0]  base,
    input  wire [bfa_pkg::CNT_W-1:0]  active,
    input  wire [bfa_pkg::CNT_W-1:0]  len,
    output bfa_pkg::scan_res_t       res
);
    import bfa_pkg::*;

    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] run_next;
    logic [CNT_W-1:0] start_reg;
    logic [CNT_W-1:0] start_next;

    // walk the free bits of one map word, carrying the open run
    always_comb
    begin
        logic [CNT_W-1:0] frame;
        run_next   = run_reg;
        start_next = start_reg;
        res.found  = 1'b0;
        res.start  = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            frame = base + CNT_W'(b);
            if (!word[b] && (frame < active))
            begin
                if (run_next == '0)
                begin
                    start_next = frame;
                end
                run_next = run_next + CNT_W'(1);
                if ((run_next == len) && !res.found)
                begin
                    res.found = 1'b1;
                    res.start = start_next;
                end
            end
            else
            begin
                run_next = '0;
            end
        end
    end

    // run state across words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            start_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            run_reg   <= '0;
            start_reg <= '0;
        end
        else if (ctrl.step)
        begin
            run_reg   <= run_next;
            start_reg <= start_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/bitmap_frame_allocator.sv -----
// Format rewrites the map words over the active frames, then gives the result. Alloc scans
// map words up to the run's end and marks the run's words, or ends when no run is found;
// free clears the words of its range; refused, zero-length or ignored go straight to the result.
// One request at a time; the single used-map memory moves 8 frames per cycle.
// Reset (async, active low) clears control, loads frame_count 256 and reserved 1,
// and leaves the map unformatted; format rewrites the used words of the map.
`default_nettype none
`include "bitmap_frame_allocator_macros.svh"
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration
    input  wire                          cfg_write_en,
    input  wire [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [bfa_pkg::CNT_W-1:0]     cfg_data,
    // request channel
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire [bfa_pkg::ACT_W-1:0]     action,
    input  wire [bfa_pkg::IDX_W-1:0]     frame_index,
    input  wire [bfa_pkg::CNT_W-1:0]     run_length,
    // result channel
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [bfa_pkg::STAT_W-1:0]   status,
    output logic [bfa_pkg::IDX_W-1:0]    first_frame
);
    import bfa_pkg::*;

    localparam int CAP       = (MAX_FRAMES > FRAME_LIMIT) ? FRAME_LIMIT : MAX_FRAMES;
    localparam int MAP_DEPTH = (CAP + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FORMAT = 5'b00010,
        S_SCAN   = 5'b00100,
        S_RMW    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    frame_count_reg, reserved_frames_reg;
    logic                formatted_reg, formatted_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    req_len_reg, req_len_next;
    logic [WCNT_W-1:0]   iss_idx_reg, iss_idx_next;
    logic                proc_valid_reg, proc_valid_next;
    logic [WCNT_W-1:0]   proc_idx_reg, proc_idx_next;
    logic [WCNT_W-1:0]   last_idx_reg, last_idx_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic                set_mode_reg, set_mode_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_first_reg, res_first_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_status_reg;
    logic [IDX_W-1:0]    out_first_reg;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;

    scan_ctrl_t          scan_ctrl;
    scan_res_t           scan_res;

    logic                accept, out_load;
    logic [CNT_W:0]      act_round;
    logic [WCNT_W-1:0]   nwords;
    logic [CNT_W:0]      proc_base, iss_base;
    logic [WORD_W-1:0]   rmw_mask, fmt_bits;
    logic [CNT_W-1:0]    fmt_n, fmt_r;
    logic [CNT_W:0]      free_end;
    logic [CNT_W-1:0]    free_hi, alloc_hi, free_hi_m1, alloc_hi_m1;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_load    = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign first_frame = out_first_reg;

    // words covered by the active frames
    assign act_round = {1'b0, active_reg} + (CNT_W+1)'(WORD_W - 1);
    assign nwords    = act_round[CNT_W:WORD_SH];
    assign proc_base = {proc_idx_reg, WORD_SH'(0)};
    assign iss_base  = {iss_idx_reg, WORD_SH'(0)};

    // format geometry
    assign fmt_n = (frame_count_reg > CNT_W'(CAP)) ? CNT_W'(CAP) : frame_count_reg;
    assign fmt_r = (reserved_frames_reg > fmt_n) ? fmt_n : reserved_frames_reg;

    // free range, clamped to the active frames
    assign free_end   = {2'b00, frame_index} + {1'b0, run_length};
    assign free_hi    = (free_end > {1'b0, active_reg}) ? active_reg : free_end[CNT_W-1:0];
    assign free_hi_m1 = free_hi - CNT_W'(1);

    // allocated range
    assign alloc_hi    = scan_res.start + req_len_reg;
    assign alloc_hi_m1 = alloc_hi - CNT_W'(1);

    // per-word bit masks for range update and format
    always_comb
    begin
        logic [CNT_W:0] f_rmw;
        logic [CNT_W:0] f_fmt;
        for (int b = 0; b < WORD_W; b++)
        begin
            f_rmw = proc_base + (CNT_W+1)'(b);
            f_fmt = iss_base + (CNT_W+1)'(b);
            rmw_mask[b] = (f_rmw >= {1'b0, lo_reg}) && (f_rmw < {1'b0, hi_reg});
            fmt_bits[b] = (f_fmt < {1'b0, hi_reg});
        end
    end

    // used map storage
    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first-fit run scanner
    bfa_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .word   (ram_rdata),
        .base   (proc_base[CNT_W-1:0]),
        .active (active_reg),
        .len    (req_len_reg),
        .res    (scan_res)
    );

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        formatted_next  = formatted_reg;
        active_next     = active_reg;
        req_len_next    = req_len_reg;
        iss_idx_next    = iss_idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        last_idx_next   = last_idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        set_mode_next   = set_mode_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = '0;
        ram_raddr       = '0;
        ram_wdata       = '0;
        scan_ctrl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_first_next  = '0;
                    req_len_next    = run_length;
                    iss_idx_next    = '0;
                    scan_ctrl.clear = 1'b1;
                    state_next      = S_DONE;
                    case (action)
                        ACT_FORMAT:
                        begin
                            active_next    = fmt_n;
                            formatted_next = 1'b1;
                            hi_next        = fmt_r;
                            if (fmt_n != '0)
                            begin
                                state_next = S_FORMAT;
                            end
                        end
                        ACT_ALLOC:
                        begin
                            if (!formatted_reg)
                            begin
                                res_status_next = ST_UNFORMATTED;
                            end
                            else if (run_length == '0)
                            begin
                                res_status_next = ST_ZERO_LEN;
                            end
                            else if (run_length > active_reg)
                            begin
                                res_status_next = ST_NO_RUN;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (!formatted_reg)
                            begin
                                res_status_next = ST_UNFORMATTED;
                            end
                            else if (({1'b0, frame_index} < active_reg) && (run_length != '0))
                            begin
                                lo_next       = {1'b0, frame_index};
                                hi_next       = free_hi;
                                set_mode_next = 1'b0;
                                iss_idx_next  = {2'b00, frame_index[IDX_W-1:WORD_SH]};
                                last_idx_next = {1'b0, free_hi_m1[CNT_W-1:WORD_SH]};
                                state_next    = S_RMW;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FORMAT:
            begin
                // write one word of the fresh map per cycle
                ram_we       = 1'b1;
                ram_waddr    = ADDR_W'(iss_idx_reg);
                ram_wdata    = fmt_bits;
                iss_idx_next = iss_idx_reg + WCNT_W'(1);
                if (iss_idx_reg == nwords - WCNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN:
            begin
                // read ahead one word while the scanner takes the previous one
                if (iss_idx_reg < nwords)
                begin
                    ram_re          = 1'b1;
                    ram_raddr       = ADDR_W'(iss_idx_reg);
                    iss_idx_next    = iss_idx_reg + WCNT_W'(1);
                    proc_valid_next = 1'b1;
                    proc_idx_next   = iss_idx_reg;
                end
                if (proc_valid_reg)
                begin
                    scan_ctrl.step = 1'b1;
                    if (scan_res.found)
                    begin
                        lo_next         = scan_res.start;
                        hi_next         = alloc_hi;
                        set_mode_next   = 1'b1;
                        iss_idx_next    = {1'b0, scan_res.start[CNT_W-1:WORD_SH]};
                        last_idx_next   = {1'b0, alloc_hi_m1[CNT_W-1:WORD_SH]};
                        proc_valid_next = 1'b0;
                        res_status_next = ST_OK;
                        res_first_next  = scan_res.start[IDX_W-1:0];
                        state_next      = S_RMW;
                    end
                    else if (proc_idx_reg == nwords - WCNT_W'(1))
                    begin
                        proc_valid_next = 1'b0;
                        res_status_next = ST_NO_RUN;
                        state_next      = S_DONE;
                    end
                end
            end

            S_RMW:
            begin
                // read word k+1 while writing back word k
                if (iss_idx_reg <= last_idx_reg)
                begin
                    ram_re          = 1'b1;
                    ram_raddr       = ADDR_W'(iss_idx_reg);
                    iss_idx_next    = iss_idx_reg + WCNT_W'(1);
                    proc_valid_next = 1'b1;
                    proc_idx_next   = iss_idx_reg;
                end
                if (proc_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(proc_idx_reg);
                    ram_wdata = set_mode_reg ? (ram_rdata | rmw_mask) : (ram_rdata & ~rmw_mask);
                    if (proc_idx_reg == last_idx_reg)
                    begin
                        proc_valid_next = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            formatted_reg  <= 1'b0;
            active_reg     <= '0;
            iss_idx_reg    <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            last_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            formatted_reg  <= formatted_next;
            active_reg     <= active_next;
            iss_idx_reg    <= iss_idx_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
            last_idx_reg   <= last_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg     <= FRAME_COUNT_RST;
            reserved_frames_reg <= RESERVED_FRAMES_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_FRAME_COUNT:     frame_count_reg     <= cfg_data;
                CFG_RESERVED_FRAMES: reserved_frames_reg <= cfg_data;
                default:             frame_count_reg     <= frame_count_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_len_reg    <= req_len_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        set_mode_reg   <= set_mode_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_first_reg  <= res_first_reg;
        end
    end

    `BFA_ASSERT_IMPL(a_ram_no_collide, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "map read and write hit the same word")
    `BFA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != S_IDLE, "accepted request did not start")
    `BFA_ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_DONE), "result appeared without a finished request")
    `BFA_ASSERT_IMPL(a_scan_in_range, clk, rst_n, proc_valid_reg && (state_reg == S_SCAN), proc_idx_reg < nwords, "scan past the active frames")
    `BFA_ASSERT_IMPL(a_rmw_in_range, clk, rst_n, proc_valid_reg && (state_reg == S_RMW), proc_idx_reg <= last_idx_reg, "range update past its last word")

endmodule
`default_nettype wire
